// ----- rtl/salc_pkg.sv -----
package salc_pkg;

  // fixed field widths
  localparam int unsigned AddrW = 64;
  localparam int unsigned TagW  = 62;
  localparam int unsigned CntW  = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFF_BITS = 2'd2;

  // configuration reset values
  localparam logic [2:0] RST_SET_BITS = 3'd4;
  localparam logic [3:0] RST_WAYS     = 4'd1;
  localparam logic [5:0] RST_OFF_BITS = 6'd4;

  // access opcodes
  localparam logic OP_SINGLE = 1'b0;
  localparam logic OP_MODIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] access_address;
    logic             opcode;
  } in_item_t;

  typedef struct packed {
    logic            was_hit;
    logic            was_evict;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] evict_total;
    logic            last_of_run;
  } out_item_t;

endpackage

// ----- rtl/set_assoc_lru_cache_tag_sim.sv -----
// each lookup reads the set, then compares and writes back through the single
//   set memory (ST_CMP); a modify item does a second lookup via ST_READ, and
//   each lookup strobes one result; busy holds new items off until the last
//   compare of the current item is done
// reset: counters clear, per-set flags mark every set empty, config returns to
//   set bits 4, ways 1, offset bits 4; no clearing pass; results cannot be stalled
module set_assoc_lru_cache_tag_sim #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [salc_pkg::CfgIdxW-1:0]             cfg_idx_i,
  input  logic [salc_pkg::CfgDataW-1:0]            cfg_data_i,
  input  logic                                     start,
  output logic                                     busy,
  input  salc_pkg::in_item_t                       item_i,
  output logic                                     result_valid_o,
  output salc_pkg::out_item_t                      result_o
);

  import salc_pkg::*;

  localparam int unsigned Sets    = 1 << MAX_SET_BITS;
  localparam int unsigned SetW    = MAX_SET_BITS;
  localparam int unsigned SbW     = $clog2(MAX_SET_BITS + 1);
  localparam int unsigned WayW    = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned RankW   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WcW     = $clog2(MAX_WAYS + 1);
  localparam int unsigned WayBits = TagW + 1 + RankW;
  localparam int unsigned RowW    = MAX_WAYS * WayBits;
  localparam logic [RankW-1:0] RankMax = RankW'(MAX_WAYS - 1);

  // configuration registers
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] off_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= RST_SET_BITS;
      ways_q     <= RST_WAYS;
      off_bits_q <= RST_OFF_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS: set_bits_q <= cfg_data_i[2:0];
        CFG_WAYS:     ways_q     <= cfg_data_i[3:0];
        CFG_OFF_BITS: off_bits_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // clamped configuration
  logic [SbW-1:0] set_eff;
  logic [WcW-1:0] ways_eff;
  logic [5:0]     off_eff;

  always_comb begin
    if (set_bits_q == '0) begin
      set_eff = SbW'(1);
    end else if (32'(set_bits_q) > MAX_SET_BITS) begin
      set_eff = SbW'(MAX_SET_BITS);
    end else begin
      set_eff = SbW'(set_bits_q);
    end
    if (ways_q == '0) begin
      ways_eff = WcW'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = WcW'(MAX_WAYS);
    end else begin
      ways_eff = WcW'(ways_q);
    end
    off_eff = (off_bits_q == '0) ? 6'd1 : off_bits_q;
  end

  // address split of the incoming item
  logic [AddrW-1:0] addr_sh;
  logic [AddrW-1:0] tag_full;
  logic [6:0]       tag_amt;
  logic [SetW-1:0]  set_acc;
  logic [TagW-1:0]  tag_acc;

  always_comb begin
    addr_sh  = item_i.access_address >> off_eff;
    set_acc  = addr_sh[SetW-1:0] & ~({SetW{1'b1}} << set_eff);
    tag_amt  = 7'(set_eff) + 7'(off_eff);
    tag_full = item_i.access_address >> tag_amt;
    tag_acc  = (tag_amt >= 7'd64) ? '0 : tag_full[TagW-1:0];
  end

  // control state
  state_e state_q, state_d;
  logic   accept;
  logic   pend_q;
  logic   ram_re;
  logic [SetW-1:0] ram_raddr;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic [Sets-1:0] row_init_q;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_CMP;
      ST_READ: state_d = ST_CMP;
      ST_CMP:  state_d = pend_q ? ST_READ : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = set_q;
    case (state_q)
      ST_IDLE: begin
        busy      = 1'b0;
        ram_re    = start;
        ram_raddr = set_acc;
      end
      ST_READ: ram_re = 1'b1;
      ST_CMP:  ram_re = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pend_q <= (item_i.opcode == OP_MODIFY);
      end else if (state_q == ST_CMP) begin
        pend_q <= 1'b0;
      end
    end
  end

  // lookup key, held for both lookups of a modify item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_acc;
      tag_q <= tag_acc;
    end
  end

  // set memory
  logic [RowW-1:0] rdata;
  logic [RowW-1:0] wrow;
  logic            ram_we;

  assign ram_we = (state_q == ST_CMP);

  salc_ram #(
    .WIDTH(RowW),
    .DEPTH(Sets)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(set_q),
    .wdata_i(wrow),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // a set never written reads as all ways empty with rank zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (ram_we) begin
      row_init_q[set_q] <= 1'b1;
    end
  end

  // compare, pick the way and age the set
  logic [TagW-1:0]  tag_a   [MAX_WAYS];
  logic             valid_a [MAX_WAYS];
  logic [RankW-1:0] rank_a  [MAX_WAYS];
  logic             hit, free_found, was_valid;
  logic [WayW-1:0]  hit_way, free_way, vic_way, sel_way;
  logic [RankW-1:0] vic_rank;
  logic [RankW:0]   old_rank;

  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    vic_way    = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      tag_a[j]   = rdata[j*WayBits+RankW+1 +: TagW];
      valid_a[j] = rdata[j*WayBits+RankW] & row_init_q[set_q];
      rank_a[j]  = row_init_q[set_q] ? rdata[j*WayBits +: RankW] : '0;
    end
    vic_rank = rank_a[0];
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (!hit && j < ways_eff && valid_a[j] && tag_a[j] == tag_q) begin
        hit     = 1'b1;
        hit_way = WayW'(j);
      end
      if (!free_found && j < ways_eff && !valid_a[j]) begin
        free_found = 1'b1;
        free_way   = WayW'(j);
      end
      if (j > 0 && j < ways_eff && rank_a[j] > vic_rank) begin
        vic_rank = rank_a[j];
        vic_way  = WayW'(j);
      end
    end
    if (hit) begin
      sel_way = hit_way;
    end else if (free_found) begin
      sel_way = free_way;
    end else begin
      sel_way = vic_way;
    end
    was_valid = hit || !free_found;
    old_rank  = was_valid ? {1'b0, rank_a[sel_way]} : {1'b1, {RankW{1'b0}}};
    wrow = rdata;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WayW'(j) == sel_way) begin
        wrow[j*WayBits +: RankW] = '0;
        if (!hit) begin
          wrow[j*WayBits+RankW]          = 1'b1;
          wrow[j*WayBits+RankW+1 +: TagW] = tag_q;
        end
      end else begin
        wrow[j*WayBits+RankW] = valid_a[j];
        if (j < ways_eff && valid_a[j] && {1'b0, rank_a[j]} < old_rank &&
            rank_a[j] < RankMax) begin
          wrow[j*WayBits +: RankW] = rank_a[j] + RankW'(1);
        end else begin
          wrow[j*WayBits +: RankW] = rank_a[j];
        end
      end
    end
  end

  // running counters and the result register
  logic [CntW-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [CntW-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;
  logic            evict;
  logic            result_valid_q;
  out_item_t       result_q;

  always_comb begin
    evict       = !hit && !free_found;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (hit && hit_cnt_q != '1) begin
      hit_cnt_d = hit_cnt_q + CntW'(1);
    end
    if (!hit && miss_cnt_q != '1) begin
      miss_cnt_d = miss_cnt_q + CntW'(1);
    end
    if (evict && evict_cnt_q != '1) begin
      evict_cnt_d = evict_cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q      <= '0;
      miss_cnt_q     <= '0;
      evict_cnt_q    <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (state_q == ST_CMP);
      if (state_q == ST_CMP) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      result_q.was_hit     <= hit;
      result_q.was_evict   <= evict;
      result_q.hit_total   <= hit_cnt_d;
      result_q.miss_total  <= miss_cnt_d;
      result_q.evict_total <= evict_cnt_d;
      result_q.last_of_run <= !pend_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // checks
  a_result_after_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_CMP))
    else $error("result strobe without a compare cycle");

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CMP))
    else $error("accepted item did not reach compare");

  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(result_o.was_hit && result_o.was_evict))
    else $error("result marked both hit and eviction");

  a_modify_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_of_run) |=> ##1
      (result_valid_o && result_o.last_of_run))
    else $error("second lookup of a modify item missing");

endmodule

// ----- rtl/salc_ram.sv -----
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sv/set_assoc_lru_cache_tag_sim_tb.sv -----
module set_assoc_lru_cache_tag_sim_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int unsigned MaxSetBits = 6;
  localparam int unsigned MaxWays    = 8;
  localparam int unsigned LineCount  = (1 << MaxSetBits) * MaxWays;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 4;

  // index with no register behind it, the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  // tag store predictor plus queue of expected lookup results
  class cache_scoreboard;
    logic [TagW-1:0] tag_mem [LineCount];
    bit              valid_mem [LineCount];
    bit [2:0]        rank_mem [LineCount];
    bit [CntW-1:0]   hit_cnt;
    bit [CntW-1:0]   miss_cnt;
    bit [CntW-1:0]   evict_cnt;
    bit [2:0]        set_bits_r;
    bit [3:0]        ways_r;
    bit [5:0]        off_bits_r;
    out_item_t       lookup_q[$];
    int              errors;

    function new();
      foreach (valid_mem[i]) begin
        tag_mem[i]   = '0;
        valid_mem[i] = 1'b0;
        rank_mem[i]  = '0;
      end
      hit_cnt    = '0;
      miss_cnt   = '0;
      evict_cnt  = '0;
      set_bits_r = RST_SET_BITS;
      ways_r     = RST_WAYS;
      off_bits_r = RST_OFF_BITS;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SET_BITS: set_bits_r = data[2:0];
        CFG_WAYS:     ways_r     = data[3:0];
        CFG_OFF_BITS: off_bits_r = data[5:0];
        default: ;
      endcase
    endfunction

    // register values as the block actually uses them
    function int unsigned eff_set_bits();
      if (set_bits_r == 0) return 1;
      return (set_bits_r > MaxSetBits) ? MaxSetBits : set_bits_r;
    endfunction

    function int unsigned eff_ways();
      if (ways_r == 0) return 1;
      return (ways_r > MaxWays) ? MaxWays : ways_r;
    endfunction

    function int unsigned eff_off_bits();
      return (off_bits_r == 0) ? 1 : off_bits_r;
    endfunction

    function int unsigned pending();
      return lookup_q.size();
    endfunction

    // make a way the most recent; younger valid ways age by one
    function void promote(int unsigned base, int unsigned ways, int unsigned way,
                          bit was_valid);
      int unsigned old_rank;
      old_rank = was_valid ? rank_mem[base + way] : 32'hFFFF;
      for (int unsigned j = 0; j < ways; j++) begin
        if (j != way && valid_mem[base + j] && rank_mem[base + j] < old_rank &&
            rank_mem[base + j] < MaxWays - 1)
          rank_mem[base + j] = rank_mem[base + j] + 1;
      end
      rank_mem[base + way] = '0;
    endfunction

    function out_item_t lookup(logic [AddrW-1:0] addr, logic last);
      int unsigned     s, b, ways, set_idx, base, hit_way, victim;
      logic [AddrW-1:0] shifted;
      logic [TagW-1:0] tag;
      bit              hit, free_found, evict;
      out_item_t       res;
      s       = eff_set_bits();
      b       = eff_off_bits();
      ways    = eff_ways();
      shifted = addr >> b;
      set_idx = int'(shifted[5:0]) & ((1 << s) - 1);
      tag     = (s + b < 64) ? TagW'(addr >> (s + b)) : '0;
      base    = set_idx * MaxWays;
      hit     = 1'b0;
      hit_way = 0;
      for (int unsigned j = 0; j < ways; j++) begin
        if (!hit && valid_mem[base + j] && tag_mem[base + j] == tag) begin
          hit     = 1'b1;
          hit_way = j;
        end
      end
      free_found = 1'b0;
      evict      = 1'b0;
      victim     = 0;
      if (hit) begin
        if (hit_cnt != '1) hit_cnt++;
        promote(base, ways, hit_way, 1'b1);
      end else begin
        if (miss_cnt != '1) miss_cnt++;
        for (int unsigned j = 0; j < ways; j++) begin
          if (!free_found && !valid_mem[base + j]) begin
            victim     = j;
            free_found = 1'b1;
          end
        end
        // no free way: replace the oldest, lowest way number on a tie
        if (!free_found) begin
          for (int unsigned j = 1; j < ways; j++)
            if (rank_mem[base + j] > rank_mem[base + victim]) victim = j;
          evict = 1'b1;
          if (evict_cnt != '1) evict_cnt++;
        end
        promote(base, ways, victim, !free_found);
        tag_mem[base + victim]   = tag;
        valid_mem[base + victim] = 1'b1;
      end
      res.was_hit     = hit;
      res.was_evict   = evict;
      res.hit_total   = hit_cnt;
      res.miss_total  = miss_cnt;
      res.evict_total = evict_cnt;
      res.last_of_run = last;
      return res;
    endfunction

    // a modify item performs two lookups of the same address
    function void note_item(in_item_t it);
      if (it.opcode == OP_MODIFY) begin
        lookup_q.push_back(lookup(it.access_address, 1'b0));
        lookup_q.push_back(lookup(it.access_address, 1'b1));
      end else begin
        lookup_q.push_back(lookup(it.access_address, 1'b1));
      end
    endfunction

    function void report(string field, logic [CntW-1:0] want, logic [CntW-1:0] got);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (lookup_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = lookup_q.pop_front();
      if (got.was_hit !== want.was_hit) report("was_hit", want.was_hit, got.was_hit);
      if (got.was_evict !== want.was_evict)
        report("was_evict", want.was_evict, got.was_evict);
      if (got.hit_total !== want.hit_total)
        report("hit_total", want.hit_total, got.hit_total);
      if (got.miss_total !== want.miss_total)
        report("miss_total", want.miss_total, got.miss_total);
      if (got.evict_total !== want.evict_total)
        report("evict_total", want.evict_total, got.evict_total);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                start;
  logic                busy;
  in_item_t            item_i;
  logic                result_valid_o;
  out_item_t           result_o;

  cache_scoreboard sb;
  int unsigned     quiet_cycles;

  set_assoc_lru_cache_tag_sim #(
    .MAX_SET_BITS(MaxSetBits),
    .MAX_WAYS    (MaxWays)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // accepted items feed the predictor, stalled progress trips the watchdog
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_item(item_i);
    if (rst_ni && ((start && !busy) || result_valid_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // offer one item, optionally after a random gap; returns at the accepting edge
  task automatic send_item(in_item_t it, int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and let every expected result come back
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CfgDataW-1:0] set_v, logic [CfgDataW-1:0] ways_v,
                              logic [CfgDataW-1:0] off_v);
    logic [CfgIdxW-1:0]  idx_list [4];
    logic [CfgDataW-1:0] data_list [4];
    idx_list  = '{CFG_SPARE, CFG_SET_BITS, CFG_WAYS, CFG_OFF_BITS};
    data_list = '{CfgDataW'($urandom), set_v, ways_v, off_v};
    cfg_we_i <= 1'b1;
    foreach (idx_list[k]) begin
      cfg_idx_i  <= idx_list[k];
      cfg_data_i <= data_list[k];
      @(posedge clk_i);
      sb.write_reg(idx_list[k], data_list[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // mostly few tags over few sets so lines get reused and evicted
  function automatic in_item_t pick_item();
    int unsigned      s, b;
    logic [AddrW-1:0] tag, set_v, off_v;
    in_item_t         it;
    s      = sb.eff_set_bits();
    b      = sb.eff_off_bits();
    it.opcode = ($urandom_range(99) < 40) ? OP_MODIFY : OP_SINGLE;
    if ($urandom_range(99) < 20) begin
      it.access_address = {$urandom(), $urandom()};
    end else begin
      tag   = $urandom_range(sb.eff_ways() + 3);
      set_v = $urandom_range(3) & ((1 << s) - 1);
      off_v = {$urandom(), $urandom()} & ((64'd1 << b) - 1);
      it.access_address = (tag << (s + b)) | (set_v << b) | off_v;
    end
    return it;
  endfunction

  task automatic run_phase(logic [CfgDataW-1:0] set_v, logic [CfgDataW-1:0] ways_v,
                           logic [CfgDataW-1:0] off_v, int unsigned idle_pct,
                           int unsigned count);
    write_config(set_v, ways_v, off_v);
    repeat (count) begin
      if ($urandom_range(39) == 0) wait_idle();
      send_item(pick_item(), idle_pct);
    end
    wait_idle();
  endtask

  initial begin
    sb           = new();
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_SET_BITS;
    cfg_data_i   = '0;
    start        = 1'b0;
    item_i       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config is 16 sets, one way, 16-byte lines
    send_item('{access_address: 64'h0, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h0, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h8, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h100, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h0, opcode: OP_MODIFY}, 0);
    send_item('{access_address: '1, opcode: OP_SINGLE}, 0);
    send_item('{access_address: '1, opcode: OP_MODIFY}, 0);
    send_item('{access_address: 64'hFFFF_FFFF_FFFF_FF0F, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h10, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h8000_0000_0000_0010, opcode: OP_MODIFY}, 0);
    send_item('{access_address: 64'h5555_5555_5555_5555, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'hAAAA_AAAA_AAAA_AAAA, opcode: OP_MODIFY}, 0);
    send_item('{access_address: 64'hAAAA_AAAA_AAAA_AAAA, opcode: OP_SINGLE}, 0);
    send_item('{access_address: 64'h5555_5555_5555_5555, opcode: OP_MODIFY}, 0);
    wait_idle();

    // random phases; store is never flushed so stale lines carry over
    run_phase(6'd1, 6'd2, 6'd1, 0, 75);
    run_phase(6'd6, 6'd8, 6'd5, 86, 75);
    run_phase(6'd0, 6'd0, 6'd0, 0, 75);
    run_phase(6'd7, 6'd15, 6'd63, 19, 75);
    run_phase(6'd3, 6'd4, 6'd32, 0, 75);
    run_phase(6'd4, 6'd3, 6'd60, 86, 75);
    run_phase(6'd2, 6'd8, 6'd2, 0, 75);
    run_phase(6'd5, 6'd5, 6'd6, 19, 75);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
